// ----- design/fat12_cluster_chain_walker_defines.svh -----
// assertion macros shared by the fat12 cluster chain walker rtl
`ifndef FAT12_CLUSTER_CHAIN_WALKER_DEFINES_SVH
`define FAT12_CLUSTER_CHAIN_WALKER_DEFINES_SVH

// condition and consequence in the same cycle
`define FAT12CCW_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("fat12ccw: same-cycle check failed");

// consequence in the cycle after the condition
`define FAT12CCW_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("fat12ccw: next-cycle check failed");

`endif

// ----- design/fat12ccw_pkg.sv -----
// types, codes and constants of the fat12 cluster chain walker
package fat12ccw_pkg;

   localparam int TABLE_BYTES  = 8192;
   localparam int TABLE_ADDR_W = $clog2(TABLE_BYTES);

   localparam logic [11:0] LINK_END  = 12'hFF8;
   localparam logic [11:0] LINK_BAD  = 12'hFF7;
   localparam logic [15:0] LINK_MASK = 16'h0FFF;

   localparam int SECTOR_BYTES = 512;
   localparam int SECTOR_SHIFT = $clog2(SECTOR_BYTES);

   localparam logic [1:0] FUNC_LOAD    = 2'd0;
   localparam logic [1:0] FUNC_START   = 2'd1;
   localparam logic [1:0] FUNC_ADVANCE = 2'd2;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_FINISHED  = 2'd1;
   localparam logic [1:0] STATUS_BAD_LINK  = 2'd2;
   localparam logic [1:0] STATUS_TOO_SMALL = 2'd3;

   localparam int          CSR_INDEX_W       = 1;
   localparam int          CSR_DATA_W        = 16;
   localparam logic [0:0]  CSR_DATA_START    = 1'b0;
   localparam logic [0:0]  CSR_SECTORS       = 1'b1;

   localparam int REQ_TDATA_W = 104;
   localparam int RSP_TDATA_W = 80;

   // last field in the lowest bits
   typedef struct packed {
      logic [6:0]  pad;
      logic [31:0] buffer_capacity;
      logic [31:0] file_length;
      logic [11:0] start_cluster;
      logic [7:0]  table_byte;
      logic [12:0] table_address;
   } req_item_type;

   typedef struct packed {
      logic [3:0]  pad;
      logic [31:0] byte_count;
      logic [31:0] first_sector;
      logic [11:0] cluster;
   } rsp_item_type;

endpackage

// ----- design/fat12ccw_ram.sv -----
// generic single-write, single-read ram with registered read data
module fat12ccw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/fat12_cluster_chain_walker.sv -----
// top level of the fat12 cluster chain walker
//
// Keeps a FAT12 allocation table in an on-chip byte store filled by load
// items and walks a cluster chain one advance item at a time. Load, start,
// unused and finishing advance items put their result into the output
// register on acceptance. An advance that emits a cluster first fetches the
// packed 12-bit link from the table memory, whose read data is registered,
// and writes the result from the link state. The store is held in two
// identical copies so the two bytes of a link come back in the same cycle.
// The store is not cleared at reset; a link read from bytes never loaded is
// undefined. An item is taken whenever the walker is not fetching a link and
// the output register is empty or being emptied in the same cycle.
`include "fat12_cluster_chain_walker_defines.svh"
module fat12_cluster_chain_walker
   import fat12ccw_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // table_address, table_byte, start_cluster, file_length, buffer_capacity
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // func
   input  logic [1:0]             req_tuser,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // cluster, first_sector, byte_count
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   // status
   output logic [1:0]             rsp_tuser,
   output logic                   rsp_tlast,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam logic STATE_IDLE = 1'b0;
   localparam logic STATE_LINK = 1'b1;

   logic         state_ff, state_in;
   logic         walking_ff, walking_in;
   logic [11:0]  link_ff, link_in;
   logic [31:0]  bytes_done_ff, bytes_done_in;
   logic [31:0]  size_goal_ff, size_goal_in;
   logic [31:0]  prod_ff, prod_in;
   logic [15:0]  data_start_ff;
   logic [7:0]   sectors_ff;

   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_item_ff, rsp_item_in;
   logic [1:0]   rsp_status_ff, rsp_status_in;
   logic         rsp_last_ff, rsp_last_in;

   req_item_type req_item;
   logic         out_free;
   logic         req_accept;
   logic         load_in_range;
   logic         adv_stop;

   logic [12:0]  off_lo, off_hi;
   logic         lo_outside, hi_outside;
   logic [7:0]   ram_lo_rd, ram_hi_rd;
   logic [7:0]   byte_lo, byte_hi;
   logic [15:0]  link_word;
   logic [11:0]  next_link;
   logic [31:0]  cluster_bytes;
   logic [31:0]  bytes_next;
   logic [31:0]  link_minus_two;
   logic         ram_we;
   logic [TABLE_ADDR_W-1:0] ram_wr_addr;

   assign req_item   = req_tdata;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == STATE_IDLE) && out_free;
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign load_in_range = 32'(req_item.table_address) < 32'(TABLE_BYTES);
   assign ram_wr_addr   = TABLE_ADDR_W'(req_item.table_address);

   // link of cluster c sits at byte offset c + c/2
   assign off_lo     = 13'(link_ff) + 13'(link_ff >> 1);
   assign off_hi     = off_lo + 13'd1;
   assign lo_outside = 32'(off_lo) >= 32'(TABLE_BYTES);
   assign hi_outside = 32'(off_hi) >= 32'(TABLE_BYTES);

   fat12ccw_ram #(.WIDTH(8), .DEPTH(TABLE_BYTES)) u_ram_lo (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (req_item.table_byte),
      .rd_addr (TABLE_ADDR_W'(off_lo)),
      .rd_data (ram_lo_rd)
   );

   fat12ccw_ram #(.WIDTH(8), .DEPTH(TABLE_BYTES)) u_ram_hi (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (req_item.table_byte),
      .rd_addr (TABLE_ADDR_W'(off_hi)),
      .rd_data (ram_hi_rd)
   );

   // link_ff is unchanged while the read is in flight, so parity and range hold
   assign byte_lo   = lo_outside ? 8'd0 : ram_lo_rd;
   assign byte_hi   = hi_outside ? 8'd0 : ram_hi_rd;
   assign link_word = {byte_hi, byte_lo};
   assign next_link = link_ff[0] ? 12'((link_word >> 4) & LINK_MASK)
                                 : 12'(link_word & LINK_MASK);

   assign cluster_bytes  = 32'(sectors_ff) << SECTOR_SHIFT;
   assign bytes_next     = bytes_done_ff + cluster_bytes;
   assign link_minus_two = 32'(link_ff) - 32'd2;

   assign adv_stop = !walking_ff || (link_ff >= LINK_END) ||
                     (bytes_done_ff >= size_goal_ff);

   always_comb begin
      state_in      = state_ff;
      walking_in    = walking_ff;
      link_in       = link_ff;
      bytes_done_in = bytes_done_ff;
      size_goal_in  = size_goal_ff;
      prod_in       = prod_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_item_in   = rsp_item_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      ram_we        = 1'b0;

      unique case (state_ff)
         STATE_IDLE: begin
            if (req_accept) begin
               prod_in       = 32'(link_minus_two * 32'(sectors_ff));
               rsp_valid_in  = 1'b1;
               rsp_item_in   = '0;
               rsp_status_in = STATUS_OK;
               rsp_last_in   = 1'b0;
               case (req_tuser)
                  FUNC_LOAD: begin
                     ram_we = load_in_range;
                  end
                  FUNC_START: begin
                     if (req_item.buffer_capacity < req_item.file_length) begin
                        rsp_status_in = STATUS_TOO_SMALL;
                        walking_in    = 1'b0;
                     end else begin
                        walking_in    = 1'b1;
                        link_in       = req_item.start_cluster;
                        bytes_done_in = '0;
                        size_goal_in  = req_item.file_length;
                     end
                  end
                  FUNC_ADVANCE: begin
                     if (adv_stop) begin
                        walking_in             = 1'b0;
                        rsp_status_in          = STATUS_FINISHED;
                        rsp_item_in.byte_count = bytes_done_ff;
                     end else begin
                        // result waits for the link fetch
                        rsp_valid_in = 1'b0;
                        state_in     = STATE_LINK;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         STATE_LINK: begin
            rsp_valid_in             = 1'b1;
            rsp_item_in              = '0;
            rsp_item_in.cluster      = link_ff;
            rsp_item_in.first_sector = 32'(data_start_ff) + prod_ff;
            rsp_item_in.byte_count   = bytes_next;
            rsp_status_in            = STATUS_OK;
            rsp_last_in              = 1'b0;
            bytes_done_in            = bytes_next;
            link_in                  = next_link;
            if (next_link == LINK_BAD) begin
               rsp_status_in = STATUS_BAD_LINK;
               rsp_last_in   = 1'b1;
               walking_in    = 1'b0;
            end else if ((next_link >= LINK_END) || (bytes_next >= size_goal_ff)) begin
               rsp_last_in = 1'b1;
               walking_in  = 1'b0;
            end
            state_in = STATE_IDLE;
         end
         default: begin
            state_in = STATE_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= STATE_IDLE;
         walking_ff    <= 1'b0;
         link_ff       <= '0;
         bytes_done_ff <= '0;
         size_goal_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
         data_start_ff <= '0;
         sectors_ff    <= 8'd1;
      end else begin
         state_ff      <= state_in;
         walking_ff    <= walking_in;
         link_ff       <= link_in;
         bytes_done_ff <= bytes_done_in;
         size_goal_ff  <= size_goal_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_DATA_START: data_start_ff <= csr_data;
               CSR_SECTORS:    sectors_ff    <= csr_data[7:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff       <= prod_in;
      rsp_item_ff   <= rsp_item_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tdata  = rsp_item_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tvalid = rsp_valid_ff;

   // the link fetch is followed by idle in the next cycle and always finds the output empty
   `FAT12CCW_ASSERT_NEXT(a_link_one_cycle, state_ff == STATE_LINK, state_ff == STATE_IDLE)
   `FAT12CCW_ASSERT_NOW(a_link_out_empty, state_ff == STATE_LINK, !rsp_valid_ff)
   // a result that ends the walk leaves no walk open
   `FAT12CCW_ASSERT_NOW(a_last_closes, rsp_valid_ff && rsp_last_ff, !walking_ff)
   `FAT12CCW_ASSERT_NOW(a_bad_is_last, rsp_valid_ff && (rsp_status_ff == STATUS_BAD_LINK),
                        rsp_last_ff)

endmodule
